// ===== rtl/pts_pkg.sv =====
// shared types, widths and constants of the pi thermal plant simulator
`default_nettype none

package pts_pkg;

    // internal fraction bits and the formats of ports and registers
    localparam int FRAC_BITS_DEFAULT = 32;
    localparam int GAIN_FRAC         = 32;
    localparam int SP_W              = 23;
    localparam int TEMP_W            = 24;
    localparam int PG_W              = 40;
    localparam int KI_W              = 32;
    localparam int RT_W              = 32;
    localparam int LIM_W             = 23;
    localparam int CNT_W             = 16;
    localparam int CFG_DATA_W        = 40;
    localparam int CFG_IDX_W         = 3;

    // multiplier operand widths for the default fraction bits
    localparam int MAG_W_DEFAULT     = FRAC_BITS_DEFAULT + 12;
    localparam int GAIN_W_DEFAULT    = FRAC_BITS_DEFAULT + 10;

    // highest legal setpoint, 120.0 with 16 fraction bits
    localparam logic [SP_W-1:0] SP_MAX = 23'd7864320;

    // register reset values
    localparam logic [PG_W-1:0]  PROP_GAIN_RST  = 40'd8589934592;
    localparam logic [KI_W-1:0]  INTEG_GAIN_RST = 32'd21474836;
    localparam logic [RT_W-1:0]  DT_TAU_RST     = 32'd2147484;
    localparam logic [LIM_W-1:0] DRIVE_LIM_RST  = 23'd7864320;
    localparam logic [CNT_W-1:0] STEP_COUNT_RST = 16'd20000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN     = 3'd0,
        CFG_INTEG_GAIN_DT = 3'd1,
        CFG_DT_OVER_TAU   = 3'd2,
        CFG_DRIVE_LIMIT   = 3'd3,
        CFG_STEP_COUNT    = 3'd4
    } cfg_idx_t;

    // datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NONE      = 5'd0,
        OP_INIT      = 5'd1,
        OP_ERR       = 5'd2,
        OP_MUL_P     = 5'd3,
        OP_ACC_P     = 5'd4,
        OP_MUL_I     = 5'd5,
        OP_ACC_I     = 5'd6,
        OP_CLAMP     = 5'd7,
        OP_D1        = 5'd8,
        OP_MUL_H     = 5'd9,
        OP_MID       = 5'd10,
        OP_DIFF      = 5'd11,
        OP_MUL_H_ACC = 5'd12,
        OP_MUL_F_ACC = 5'd13,
        OP_ADD_D     = 5'd14,
        OP_MUL_S     = 5'd15,
        OP_MUL_D     = 5'd16,
        OP_UPD       = 5'd17,
        OP_LOAD_OUT  = 5'd18
    } op_t;

    typedef struct packed {
        logic capture;
        op_t  op;
    } dp_cmd_t;

    typedef struct packed {
        logic sp_ok;
        logic count_zero;
        logic last_step;
        logic mul_done;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/pts_if.sv =====
// valid/ready channel interfaces for setpoints and results
`default_nettype none

interface pts_in_if;
    logic                     valid;
    logic                     ready;
    logic [pts_pkg::SP_W-1:0] setpoint;

    modport source (output valid, output setpoint, input ready);
    modport sink   (input valid, input setpoint, output ready);
endinterface

interface pts_out_if;
    logic                       valid;
    logic                       ready;
    logic [pts_pkg::TEMP_W-1:0] final_temperature;
    logic                       valid_res;

    modport source (output valid, output final_temperature, output valid_res, input ready);
    modport sink   (input valid, input final_temperature, input valid_res, output ready);
endinterface

`default_nettype wire

// ===== rtl/pts_mul.sv =====
// two-pass unsigned multiplier, one half of the magnitude per cycle
`default_nettype none

module pts_mul #(
    parameter int MAG_W  = pts_pkg::MAG_W_DEFAULT,
    parameter int GAIN_W = pts_pkg::GAIN_W_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [MAG_W-1:0]                  mag,
    input  wire logic [GAIN_W-1:0]                 gain,
    output logic      [2*((MAG_W+1)/2)+GAIN_W-1:0] product,
    output logic                                   done
);

    localparam int HALF   = (MAG_W + 1) / 2;
    localparam int PART_W = HALF + GAIN_W;
    localparam int PROD_W = 2 * HALF + GAIN_W;

    logic [2*HALF-1:0] mag_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic              run_reg, run_next;
    logic              hi_reg, hi_next;
    logic              done_reg, done_next;
    logic [HALF-1:0]   half_sel;
    logic [PART_W-1:0] part;

    assign half_sel = hi_reg ? mag_reg[2*HALF-1:HALF] : mag_reg[HALF-1:0];
    assign part     = PART_W'(half_sel) * PART_W'(gain_reg);

    always_comb
    begin
        run_next  = run_reg;
        hi_next   = hi_reg;
        done_next = 1'b0;
        acc_next  = acc_reg;
        if (start)
        begin
            run_next = 1'b1;
            hi_next  = 1'b0;
        end
        else if (run_reg && !hi_reg)
        begin
            acc_next = PROD_W'(part);
            hi_next  = 1'b1;
        end
        else if (run_reg)
        begin
            acc_next  = acc_reg + (PROD_W'(part) << HALF);
            run_next  = 1'b0;
            hi_next   = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            hi_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            hi_reg   <= hi_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_reg  <= (2*HALF)'(mag);
            gain_reg <= gain;
        end
        acc_reg <= acc_next;
    end

    assign product = acc_reg;
    assign done    = done_reg;

endmodule

`default_nettype wire

// ===== rtl/pts_datapath.sv =====
// registers, saturating arithmetic and multiplier of the plant simulation
`default_nettype none

module pts_datapath #(
    parameter int FRAC_BITS = pts_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [pts_pkg::SP_W-1:0]        setpoint,
    output logic      [pts_pkg::TEMP_W-1:0]      final_temperature,
    output logic                                 valid_res,
    input  wire logic                            cfg_wr_en,
    input  wire logic [pts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pts_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire pts_pkg::dp_cmd_t                cmd,
    output pts_pkg::dp_status_t                  status
);

    localparam int W       = FRAC_BITS + 10;
    localparam int W1      = W + 1;
    localparam int SW      = W + 3;
    localparam int MW      = W + 2;
    localparam int GW      = (W > pts_pkg::PG_W) ? W : pts_pkg::PG_W;
    localparam int HALF    = (MW + 1) / 2;
    localparam int AW      = 2 * HALF + GW;
    localparam int GF      = pts_pkg::GAIN_FRAC;
    localparam int QW      = AW - GF;
    localparam int K6      = W + 2 - (W % 2);
    localparam int PORT_SH = FRAC_BITS - 16;

    localparam logic [63:0]           RECIP6_FULL = ((64'd1 << K6) + 64'd5) / 64'd6;
    localparam logic [GW-1:0]         RECIP6      = RECIP6_FULL[GW-1:0];
    localparam logic [MW-1:0]         DIV_BIAS    = MW'(5);
    localparam logic signed [W-1:0]   MAXV        = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]   MINV        = {1'b1, {(W-1){1'b0}}};
    localparam logic [QW:0]           LIM_Q       = (QW+1)'(1) << (W - 1);
    localparam logic signed [W-1:0]   PORT_MAX    = W'(2**(pts_pkg::TEMP_W-1) - 1);
    localparam logic signed [W-1:0]   PORT_MIN    = -PORT_MAX - W'(1);

    typedef enum logic [1:0] {
        MK_SH32 = 2'd0,
        MK_SH33 = 2'd1,
        MK_DIV6 = 2'd2
    } mul_kind_t;

    function automatic logic signed [W-1:0] sat_w(input logic signed [W:0] x);
        logic signed [W-1:0] r;
        if (x[W] != x[W-1])
            r = x[W] ? MINV : MAXV;
        else
            r = x[W-1:0];
        return r;
    endfunction

    // configuration
    logic [pts_pkg::PG_W-1:0]  prop_gain_reg;
    logic [pts_pkg::KI_W-1:0]  integ_gain_reg;
    logic [pts_pkg::RT_W-1:0]  dt_tau_reg;
    logic [pts_pkg::LIM_W-1:0] drive_lim_reg;
    logic [pts_pkg::CNT_W-1:0] step_count_reg;

    // run state
    logic [pts_pkg::SP_W-1:0]  sp_reg;
    logic [pts_pkg::CNT_W-1:0] step_reg;
    logic signed [W-1:0]       temp_reg, lerr_reg, drive_reg, err_reg, cand_reg;
    logic signed [W-1:0]       d_reg, mid_reg, res_reg;
    logic signed [SW-1:0]      sum_reg;
    mul_kind_t                 kind_reg;
    logic                      neg_reg;
    logic [pts_pkg::TEMP_W-1:0] out_temp_reg;
    logic                      out_vres_reg;

    logic signed [W-1:0]       sp_int, lim_int, err_next, d1_val, post, tsh;
    logic [pts_pkg::TEMP_W-1:0] port_temp;

    // multiplier operand selection
    logic signed [SW-1:0]      op_a, abs_a;
    logic [GW-1:0]             op_gain;
    mul_kind_t                 op_kind;
    logic                      op_start, op_neg;
    logic [MW-1:0]             op_mag;
    logic [AW-1:0]             product;
    logic                      mul_done;

    // post-processing of the product
    logic [QW-1:0]             q_sel;
    logic                      rem_sel;
    logic [QW:0]               q_round;
    logic [AW-K6-1:0]          q_div;
    logic signed [W-1:0]       q_div_w;

    assign sp_int   = $signed(W'(sp_reg) << PORT_SH);
    assign lim_int  = $signed(W'(drive_lim_reg) << PORT_SH);
    assign err_next = sat_w(W1'(sp_int) - W1'(temp_reg));
    assign d1_val   = sat_w(W1'(cand_reg) - W1'(temp_reg));

    always_comb
    begin
        op_a     = '0;
        op_gain  = '0;
        op_kind  = MK_SH32;
        op_start = 1'b0;
        unique case (cmd.op)
            pts_pkg::OP_MUL_P:
            begin
                op_a     = SW'(sat_w(W1'(err_reg) - W1'(lerr_reg)));
                op_gain  = GW'(prop_gain_reg);
                op_start = 1'b1;
            end
            pts_pkg::OP_MUL_I:
            begin
                op_a     = SW'(err_reg);
                op_gain  = GW'(integ_gain_reg);
                op_start = 1'b1;
            end
            pts_pkg::OP_MUL_H, pts_pkg::OP_MUL_H_ACC:
            begin
                op_a     = SW'(d_reg);
                op_gain  = GW'(dt_tau_reg);
                op_kind  = MK_SH33;
                op_start = 1'b1;
            end
            pts_pkg::OP_MUL_F_ACC:
            begin
                op_a     = SW'(d_reg);
                op_gain  = GW'(dt_tau_reg);
                op_start = 1'b1;
            end
            pts_pkg::OP_MUL_S:
            begin
                op_a     = sum_reg;
                op_gain  = GW'(dt_tau_reg);
                op_start = 1'b1;
            end
            pts_pkg::OP_MUL_D:
            begin
                op_a     = SW'(res_reg);
                op_gain  = RECIP6;
                op_kind  = MK_DIV6;
                op_start = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // sign and magnitude; floor division by six works on |x|+5 for negative x
    assign op_neg = op_a[SW-1];
    assign abs_a  = op_neg ? -op_a : op_a;
    assign op_mag = MW'(abs_a) + ((op_kind == MK_DIV6 && op_neg) ? DIV_BIAS : '0);

    pts_mul #(
        .MAG_W  (MW),
        .GAIN_W (GW)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (op_start),
        .mag     (op_mag),
        .gain    (op_gain),
        .product (product),
        .done    (mul_done)
    );

    always_comb
    begin
        if (kind_reg == MK_SH33)
        begin
            q_sel   = QW'(product[AW-1:GF+1]);
            rem_sel = |product[GF:0];
        end
        else
        begin
            q_sel   = product[AW-1:GF];
            rem_sel = |product[GF-1:0];
        end
        q_round = (QW+1)'(q_sel) + (QW+1)'(neg_reg && rem_sel);
        q_div   = product[AW-1:K6];
        q_div_w = $signed(W'(q_div));
        case (kind_reg)
            MK_DIV6:
                post = neg_reg ? -q_div_w : q_div_w;
            default:
            begin
                if (neg_reg)
                    post = (q_round >= LIM_Q) ? MINV : -$signed(W'(q_round));
                else
                    post = ((QW+1)'(q_sel) >= LIM_Q) ? MAXV : $signed(W'(q_sel));
            end
        endcase
    end

    // floor to 16 fraction bits, then saturate to the port range
    always_comb
    begin
        tsh = temp_reg >>> PORT_SH;
        if (tsh > PORT_MAX)
            port_temp = PORT_MAX[pts_pkg::TEMP_W-1:0];
        else if (tsh < PORT_MIN)
            port_temp = PORT_MIN[pts_pkg::TEMP_W-1:0];
        else
            port_temp = tsh[pts_pkg::TEMP_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg  <= pts_pkg::PROP_GAIN_RST;
            integ_gain_reg <= pts_pkg::INTEG_GAIN_RST;
            dt_tau_reg     <= pts_pkg::DT_TAU_RST;
            drive_lim_reg  <= pts_pkg::DRIVE_LIM_RST;
            step_count_reg <= pts_pkg::STEP_COUNT_RST;
            step_reg       <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (pts_pkg::cfg_idx_t'(cfg_index))
                    pts_pkg::CFG_PROP_GAIN:     prop_gain_reg  <= cfg_data[pts_pkg::PG_W-1:0];
                    pts_pkg::CFG_INTEG_GAIN_DT: integ_gain_reg <= cfg_data[pts_pkg::KI_W-1:0];
                    pts_pkg::CFG_DT_OVER_TAU:   dt_tau_reg     <= cfg_data[pts_pkg::RT_W-1:0];
                    pts_pkg::CFG_DRIVE_LIMIT:   drive_lim_reg  <= cfg_data[pts_pkg::LIM_W-1:0];
                    pts_pkg::CFG_STEP_COUNT:    step_count_reg <= cfg_data[pts_pkg::CNT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.op == pts_pkg::OP_INIT)
                step_reg <= '0;
            else if (cmd.op == pts_pkg::OP_UPD)
                step_reg <= step_reg + pts_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            sp_reg <= setpoint;
        if (op_start)
        begin
            kind_reg <= op_kind;
            neg_reg  <= op_neg;
        end
        if (mul_done)
            res_reg <= post;
        unique case (cmd.op)
            pts_pkg::OP_INIT:
            begin
                temp_reg  <= '0;
                lerr_reg  <= sp_int;
                drive_reg <= '0;
            end
            pts_pkg::OP_ERR:       err_reg  <= err_next;
            pts_pkg::OP_ACC_P:     cand_reg <= sat_w(W1'(drive_reg) + W1'(res_reg));
            pts_pkg::OP_ACC_I:     cand_reg <= sat_w(W1'(cand_reg) + W1'(res_reg));
            pts_pkg::OP_CLAMP:
            begin
                if (cand_reg > lim_int)
                    cand_reg <= lim_int;
                else if (cand_reg < -lim_int)
                    cand_reg <= -lim_int;
            end
            pts_pkg::OP_D1:
            begin
                d_reg   <= d1_val;
                sum_reg <= SW'(d1_val);
            end
            pts_pkg::OP_MID:       mid_reg  <= sat_w(W1'(temp_reg) + W1'(res_reg));
            pts_pkg::OP_DIFF:      d_reg    <= sat_w(W1'(cand_reg) - W1'(mid_reg));
            pts_pkg::OP_MUL_H_ACC,
            pts_pkg::OP_MUL_F_ACC: sum_reg  <= sum_reg + (SW'(d_reg) <<< 1);
            pts_pkg::OP_ADD_D:     sum_reg  <= sum_reg + SW'(d_reg);
            pts_pkg::OP_UPD:
            begin
                temp_reg  <= sat_w(W1'(temp_reg) + W1'(res_reg));
                drive_reg <= cand_reg;
                lerr_reg  <= err_reg;
            end
            pts_pkg::OP_LOAD_OUT:
            begin
                out_temp_reg <= status.sp_ok ? port_temp : '0;
                out_vres_reg <= status.sp_ok;
            end
            default:
            begin
            end
        endcase
    end

    assign status.sp_ok      = (sp_reg <= pts_pkg::SP_MAX);
    assign status.count_zero = (step_count_reg == '0);
    assign status.last_step  = ((pts_pkg::CNT_W+1)'(step_reg) + (pts_pkg::CNT_W+1)'(1))
                               == (pts_pkg::CNT_W+1)'(step_count_reg);
    assign status.mul_done   = mul_done;

    assign final_temperature = out_temp_reg;
    assign valid_res         = out_vres_reg;

endmodule

`default_nettype wire

// ===== rtl/pts_ctrl.sv =====
// sequencer of one simulation step and of the input and output handshakes
`default_nettype none

module pts_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire pts_pkg::dp_status_t status,
    output pts_pkg::dp_cmd_t         cmd
);

    typedef enum logic [24:0] {
        ST_IDLE  = 25'h0000001,
        ST_CHECK = 25'h0000002,
        ST_INIT  = 25'h0000004,
        ST_ERR   = 25'h0000008,
        ST_MULP  = 25'h0000010,
        ST_ACCP  = 25'h0000020,
        ST_MULI  = 25'h0000040,
        ST_ACCI  = 25'h0000080,
        ST_CLAMP = 25'h0000100,
        ST_D1    = 25'h0000200,
        ST_MH1   = 25'h0000400,
        ST_MID1  = 25'h0000800,
        ST_DIF1  = 25'h0001000,
        ST_MH2   = 25'h0002000,
        ST_MID2  = 25'h0004000,
        ST_DIF2  = 25'h0008000,
        ST_MF3   = 25'h0010000,
        ST_MID3  = 25'h0020000,
        ST_DIF3  = 25'h0040000,
        ST_ADD4  = 25'h0080000,
        ST_MS    = 25'h0100000,
        ST_MD    = 25'h0200000,
        ST_UPD   = 25'h0400000,
        ST_WAIT  = 25'h0800000,
        ST_FIN   = 25'h1000000
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.capture    = in_valid && in_ready;
        cmd.op         = pts_pkg::OP_NONE;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_CHECK;
            ST_CHECK:
                state_next = status.sp_ok ? ST_INIT : ST_FIN;
            ST_INIT:
            begin
                cmd.op     = pts_pkg::OP_INIT;
                state_next = status.count_zero ? ST_FIN : ST_ERR;
            end
            ST_ERR:
            begin
                cmd.op     = pts_pkg::OP_ERR;
                state_next = ST_MULP;
            end
            ST_MULP:
            begin
                cmd.op     = pts_pkg::OP_MUL_P;
                ret_next   = ST_ACCP;
                state_next = ST_WAIT;
            end
            ST_ACCP:
            begin
                cmd.op     = pts_pkg::OP_ACC_P;
                state_next = ST_MULI;
            end
            ST_MULI:
            begin
                cmd.op     = pts_pkg::OP_MUL_I;
                ret_next   = ST_ACCI;
                state_next = ST_WAIT;
            end
            ST_ACCI:
            begin
                cmd.op     = pts_pkg::OP_ACC_I;
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                cmd.op     = pts_pkg::OP_CLAMP;
                state_next = ST_D1;
            end
            ST_D1:
            begin
                cmd.op     = pts_pkg::OP_D1;
                state_next = ST_MH1;
            end
            ST_MH1:
            begin
                cmd.op     = pts_pkg::OP_MUL_H;
                ret_next   = ST_MID1;
                state_next = ST_WAIT;
            end
            ST_MID1:
            begin
                cmd.op     = pts_pkg::OP_MID;
                state_next = ST_DIF1;
            end
            ST_DIF1:
            begin
                cmd.op     = pts_pkg::OP_DIFF;
                state_next = ST_MH2;
            end
            ST_MH2:
            begin
                cmd.op     = pts_pkg::OP_MUL_H_ACC;
                ret_next   = ST_MID2;
                state_next = ST_WAIT;
            end
            ST_MID2:
            begin
                cmd.op     = pts_pkg::OP_MID;
                state_next = ST_DIF2;
            end
            ST_DIF2:
            begin
                cmd.op     = pts_pkg::OP_DIFF;
                state_next = ST_MF3;
            end
            ST_MF3:
            begin
                cmd.op     = pts_pkg::OP_MUL_F_ACC;
                ret_next   = ST_MID3;
                state_next = ST_WAIT;
            end
            ST_MID3:
            begin
                cmd.op     = pts_pkg::OP_MID;
                state_next = ST_DIF3;
            end
            ST_DIF3:
            begin
                cmd.op     = pts_pkg::OP_DIFF;
                state_next = ST_ADD4;
            end
            ST_ADD4:
            begin
                cmd.op     = pts_pkg::OP_ADD_D;
                state_next = ST_MS;
            end
            ST_MS:
            begin
                cmd.op     = pts_pkg::OP_MUL_S;
                ret_next   = ST_MD;
                state_next = ST_WAIT;
            end
            ST_MD:
            begin
                cmd.op     = pts_pkg::OP_MUL_D;
                ret_next   = ST_UPD;
                state_next = ST_WAIT;
            end
            ST_UPD:
            begin
                cmd.op     = pts_pkg::OP_UPD;
                state_next = status.last_step ? ST_FIN : ST_ERR;
            end
            ST_WAIT:
                if (status.mul_done)
                    state_next = ret_reg;
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = pts_pkg::OP_LOAD_OUT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        status.mul_done |-> state_reg == ST_WAIT)
        else $error("multiplier finished outside the wait state");

    a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_CHECK)
        else $error("accepted setpoint not followed by range check");

    a_last_step_fin: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_UPD && status.last_step |=> state_reg == ST_FIN)
        else $error("run did not finish after its last step");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_FIN)
        else $error("result raised outside the finish state");
`endif

endmodule

`default_nettype wire

// ===== rtl/pi_thermal_plant_simulator_top.sv =====
// top level of the pi-controlled first-order thermal plant simulator
// a setpoint is taken only in idle, after the previous run has loaded its
//   result; each step is a sequence of operations around the shared
//   two-pass multiplier
// reset: asynchronous, active low; configuration registers return to their
//   defaults, channels go idle, no clearing pass
`default_nettype none

module pi_thermal_plant_simulator_top #(
    parameter int FRAC_BITS = pts_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    pts_in_if.sink                               in_ch,
    pts_out_if.source                            out_ch,
    input  wire logic                            cfg_wr_en,
    input  wire logic [pts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pts_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // command and status between sequencer and datapath
    pts_pkg::dp_cmd_t    cmd;
    pts_pkg::dp_status_t status;

    // the sequencer owns both handshakes: a setpoint transfer is taken only
    // in idle, and the result register holds a finished result until its
    // transfer, so a new setpoint may start while a result still waits
    pts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // the datapath keeps configuration, the plant state, the rk4 stage
    // values and the result register; all products go through one
    // two-pass multiplier whose registered product is rounded toward minus
    // infinity, and the final divide by six is a reciprocal product on the
    // same unit
    pts_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .setpoint          (in_ch.setpoint),
        .final_temperature (out_ch.final_temperature),
        .valid_res         (out_ch.valid_res),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .cmd               (cmd),
        .status            (status)
    );

endmodule

`default_nettype wire
